// File: rtl/core/srvs_pkg.sv
// shared constants, types and state encodings for the scan range smoothing block
`default_nettype none
package srvs_pkg;

  localparam int DATA_W      = 16;
  localparam int HALF_WINDOW = 2;
  localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
  localparam int IDX_W       = $clog2(WIN_LEN);
  localparam int CNT_W       = $clog2(WIN_LEN + 1);
  localparam int SUM_W       = DATA_W + CNT_W;
  localparam int DIV_CNT_W   = $clog2(DATA_W);
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 2'd1;

  localparam logic [DATA_W-1:0] MIN_RANGE_RST = 16'd100;
  localparam logic [DATA_W-1:0] MAX_RANGE_RST = 16'd10000;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    AVG_IDLE,
    AVG_SUM,
    AVG_DIV
  } avg_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_CALC,
    ST_PUSH
  } ctl_state_t;

  typedef struct packed {
    logic start;
    idx_t lo;
    idx_t hi;
  } avg_req_t;

  typedef struct packed {
    logic  done;
    data_t quo;
  } avg_resp_t;

endpackage
`default_nettype wire

// File: rtl/core/scan_range_validate_smooth.sv
// top level: range validation, sample window, result sequencer and output register
//
// Input channel (in_valid / in_stall): one range sample per transaction with
// in_is_finite and in_scan_last. Samples that are non-finite or outside
// [min_range_mm, max_range_mm] are replaced by max_range_mm, then averaged
// over a centered window of 2*HALF_WINDOW+1 samples that shrinks at scan edges.
// Output channel (out_valid / out_stall): one smoothed sample per transaction,
// out_last on the final result of a scan. Results are held until the scan is
// one window long; on in_scan_last the pending ones are flushed, and a short
// scan comes out cleaned but not averaged.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 min_range_mm,
// index 1 max_range_mm; write only while idle.
// Flow: every result passes the shared averager, a serial accumulate over the
// window span followed by a 16-step divide. An item that yields no result does
// not stall the input. The input stalls until all results of an item are in the
// output register; a stalled output register holds the sequencer. Reset clears
// the scan state, restores the register defaults and empties the output register.
`default_nettype none
module scan_range_validate_smooth (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [15:0]                    in_range_mm,
  input  wire logic                           in_is_finite,
  input  wire logic                           in_scan_last,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [15:0]                         out_smoothed_mm,
  output logic                                out_last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [srvs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data
);
  import srvs_pkg::*;

  localparam idx_t HI_FULL = idx_t'(2 * HALF_WINDOW);
  localparam idx_t BASE_FIRST = idx_t'(HALF_WINDOW);

  ctl_state_t state_r, state_nxt;
  data_t      min_r, max_r;
  data_t      win_r [WIN_LEN];
  cnt_t       sc_r, sc_nxt;
  logic       started_r, started_nxt;
  cnt_t       n_r, n_nxt;
  idx_t       base_r, base_nxt;
  logic       raw_r, raw_nxt;
  logic       last_r, last_nxt;
  idx_t       j_r, j_nxt;
  logic       ov_r, ov_nxt;
  data_t      od_r, od_nxt;
  logic       ol_r, ol_nxt;

  logic       in_acc;
  data_t      clean;
  cnt_t       sc_inc;
  logic       full;
  logic       has_res;
  cnt_t       n_calc;
  logic       out_free;
  logic       final_res;
  cnt_t       raw_off;
  avg_req_t   req;
  avg_resp_t  resp;
  idx_t       rd_idx;
  data_t      rd_data;

  srvs_avg_unit u_avg (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data),
    .rd_idx  (rd_idx),
    .resp    (resp)
  );

  assign rd_data = win_r[rd_idx];

  assign in_stall        = (state_r != ST_IDLE);
  assign in_acc          = in_valid && !in_stall;
  assign cfg_ready       = 1'b1;
  assign out_valid       = ov_r;
  assign out_smoothed_mm = od_r;
  assign out_last        = ol_r;

  assign clean = (in_is_finite && (in_range_mm >= min_r) && (in_range_mm <= max_r))
                 ? in_range_mm : max_r;
  assign sc_inc  = (sc_r < cnt_t'(WIN_LEN)) ? sc_r + cnt_t'(1) : sc_r;
  assign full    = (sc_inc == cnt_t'(WIN_LEN));
  assign has_res = full || in_scan_last;
  assign n_calc  = full ? (cnt_t'(started_r ? 1 : HALF_WINDOW + 1)
                           + (in_scan_last ? cnt_t'(HALF_WINDOW) : cnt_t'(0)))
                        : sc_inc;

  assign out_free  = !ov_r || !out_stall;
  assign final_res = (cnt_t'(j_r) == n_r - cnt_t'(1));
  assign raw_off   = sc_r - cnt_t'(1) - cnt_t'(j_r);

  always_comb begin
    req.start = (state_r == ST_START);
    if (raw_r) begin
      req.lo = raw_off[IDX_W-1:0];
      req.hi = raw_off[IDX_W-1:0];
    end else if (j_r <= base_r) begin
      req.lo = base_r - j_r;
      req.hi = HI_FULL;
    end else begin
      req.lo = '0;
      req.hi = HI_FULL - (j_r - base_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && has_res) state_nxt = ST_START;
      ST_START: state_nxt = ST_CALC;
      ST_CALC:  if (resp.done) state_nxt = ST_PUSH;
      ST_PUSH:  if (out_free) state_nxt = final_res ? ST_IDLE : ST_START;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    sc_nxt      = sc_r;
    started_nxt = started_r;
    n_nxt       = n_r;
    base_nxt    = base_r;
    raw_nxt     = raw_r;
    last_nxt    = last_r;
    j_nxt       = j_r;
    ov_nxt      = ov_r && out_stall;
    od_nxt      = od_r;
    ol_nxt      = ol_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sc_nxt   = sc_inc;
          n_nxt    = n_calc;
          base_nxt = started_r ? idx_t'(0) : BASE_FIRST;
          raw_nxt  = !full;
          last_nxt = in_scan_last;
          j_nxt    = '0;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = resp.quo;
          ol_nxt = last_r && final_res;
          j_nxt  = j_r + idx_t'(1);
          if (final_res) begin
            if (last_r) begin
              sc_nxt      = '0;
              started_nxt = 1'b0;
            end else begin
              started_nxt = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      sc_r      <= '0;
      started_r <= 1'b0;
      ov_r      <= 1'b0;
      min_r     <= MIN_RANGE_RST;
      max_r     <= MAX_RANGE_RST;
    end else begin
      state_r   <= state_nxt;
      sc_r      <= sc_nxt;
      started_r <= started_nxt;
      ov_r      <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_RANGE: min_r <= cfg_data;
          REG_MAX_RANGE: max_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    base_r <= base_nxt;
    raw_r  <= raw_nxt;
    last_r <= last_nxt;
    j_r    <= j_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
    if (in_acc) begin
      win_r[0] <= clean;
      for (int i = 1; i < WIN_LEN; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    resp.done |-> state_r == ST_CALC)
    else $error("averager finished outside of calc state");

  a_scan_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= cnt_t'(WIN_LEN))
    else $error("scan count beyond window length");

  a_result_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) |-> (cnt_t'(j_r) < n_r))
    else $error("result index beyond result count");

  a_push_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && out_free) |=> ov_r)
    else $error("pushed result did not reach the output register");

endmodule
`default_nettype wire

// File: rtl/core/srvs_avg_unit.sv
// iterative window averager: serial accumulate then restoring divide with round half up
`default_nettype none
module srvs_avg_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire srvs_pkg::avg_req_t req,
  input  wire srvs_pkg::data_t    rd_data,
  output srvs_pkg::idx_t          rd_idx,
  output srvs_pkg::avg_resp_t     resp
);
  import srvs_pkg::*;

  avg_state_t           state_r, state_nxt;
  idx_t                 idx_r, idx_nxt;
  idx_t                 hi_r, hi_nxt;
  logic [SUM_W-1:0]     acc_r, acc_nxt;
  cnt_t                 d_r, d_nxt;
  cnt_t                 rem_r, rem_nxt;
  data_t                quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;

  cnt_t                 d_new;
  logic [SUM_W-1:0]     acc_sum;
  logic [CNT_W:0]       shifted;
  logic                 ge;

  assign d_new   = cnt_t'(req.hi) - cnt_t'(req.lo) + cnt_t'(1);
  assign acc_sum = acc_r + SUM_W'(rd_data);
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign ge      = shifted >= {1'b0, d_r};

  assign rd_idx    = idx_r;
  assign resp.done = done_r;
  assign resp.quo  = quo_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      AVG_IDLE: if (req.start) state_nxt = AVG_SUM;
      AVG_SUM:  if (idx_r == hi_r) state_nxt = AVG_DIV;
      AVG_DIV:  if (cnt_r == '0) state_nxt = AVG_IDLE;
      default:  state_nxt = AVG_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt  = idx_r;
    hi_nxt   = hi_r;
    acc_nxt  = acc_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    case (state_r)
      AVG_IDLE: begin
        if (req.start) begin
          idx_nxt = req.lo;
          hi_nxt  = req.hi;
          d_nxt   = d_new;
          acc_nxt = SUM_W'(d_new >> 1);
        end
      end
      AVG_SUM: begin
        acc_nxt = acc_sum;
        if (idx_r == hi_r) begin
          rem_nxt = acc_sum[SUM_W-1:DATA_W];
          quo_nxt = acc_sum[DATA_W-1:0];
          cnt_nxt = DIV_CNT_W'(DATA_W - 1);
        end else begin
          idx_nxt = idx_r + idx_t'(1);
        end
      end
      AVG_DIV: begin
        rem_nxt = ge ? cnt_t'(shifted - {1'b0, d_r}) : shifted[CNT_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], ge};
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) done_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AVG_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    hi_r  <= hi_nxt;
    acc_r <= acc_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

endmodule
`default_nettype wire
